// File: sv/ultrasonic_echo_ranger_defines.svh
// Assertion macros shared by the RTL.
`ifndef ULTRASONIC_ECHO_RANGER_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define UER_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define UER_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/uer_pkg.sv
`default_nettype none

package uer_pkg;

    // Design constants.
    localparam int ECHO_WIDTH_BITS = 20;
    localparam int MAX_SAMPLES     = 8;

    // Field and register widths.
    localparam int TRIG_W    = 10;
    localparam int TPC_W     = 8;
    localparam int SCNT_W    = 4;
    localparam int SETTLE_W  = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int SUM_W     = 24;
    localparam int DIST_W    = 16;
    localparam int PCNT_W    = 16;

    // Derived widths.
    localparam int SAMPLE_W = $clog2(MAX_SAMPLES + 1);
    localparam int EFF_W    = (SAMPLE_W > SCNT_W) ? SAMPLE_W : SCNT_W;
    localparam int NUM_W    = SUM_W + 4;
    localparam int DEN_W    = TPC_W + EFF_W;
    localparam int DCNT_W   = $clog2(NUM_W + 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_CM  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TICKS  = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [TRIG_W-1:0]   TRIGGER_TICKS_RST = 10'd100;
    localparam logic [TPC_W-1:0]    TICKS_PER_CM_RST  = 8'd58;
    localparam logic [SCNT_W-1:0]   SAMPLE_COUNT_RST  = 4'd5;
    localparam logic [SETTLE_W-1:0] SETTLE_TICKS_RST  = 16'd10000;

    // Number of samples actually averaged: zero counts as one, and the
    // count is clamped to the sample capacity.
    function automatic logic [EFF_W-1:0] eff_samples(input logic [SCNT_W-1:0] cnt);
        logic [EFF_W-1:0] wide;
        wide = EFF_W'(cnt);
        if (wide == '0)
        begin
            return EFF_W'(1);
        end
        else if (wide > EFF_W'(MAX_SAMPLES))
        begin
            return EFF_W'(MAX_SAMPLES);
        end
        return wide;
    endfunction

endpackage

`default_nettype wire

// File: sv/ultrasonic_echo_ranger.sv
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+-------------------------------------------
// input    | in        | in_valid/in_stall  | start_req, echo_level
// output   | out       | out_valid/out_stall| trigger_level, busy_res, result_valid,
//          |           |                    | distance_sixteenths
// config   | in        | cfg_we             | cfg_index, cfg_data
//
// Every input transaction is one microsecond tick and yields exactly one output
// transaction. The average for the tick that finishes a measurement set is
// produced by a restoring divider that retires one quotient bit per cycle
// over the 28-bit numerator, and in_stall stays high meanwhile. Reset (rst_n
// low) returns the controller to idle and the configuration registers to their
// defaults. A stalled result holds in the output register, and in_stall follows
// out_stall while it is occupied.

`default_nettype none

`include "ultrasonic_echo_ranger_defines.svh"

module ultrasonic_echo_ranger
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           start_req,
    input  wire logic                           echo_level,

    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic                                trigger_level,
    output logic                                busy_res,
    output logic                                result_valid,
    output logic [uer_pkg::DIST_W-1:0]          distance_sixteenths,

    input  wire logic                           cfg_we,
    input  wire logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [uer_pkg::CFG_W-1:0]      cfg_data
);

    // Measurement phases.
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_TRIG   = 3'd1;
    localparam logic [2:0] PH_WAIT   = 3'd2;
    localparam logic [2:0] PH_MEAS   = 3'd3;
    localparam logic [2:0] PH_SETTLE = 3'd4;

    localparam logic [uer_pkg::ECHO_WIDTH_BITS-1:0] WIDTH_MAX = '1;
    localparam logic [uer_pkg::SUM_W-1:0]           SUM_MAX   = '1;
    localparam logic [uer_pkg::DIST_W-1:0]          DIST_MAX  = '1;

    // Configuration registers.
    logic [uer_pkg::TRIG_W-1:0]   trig_ticks_reg;
    logic [uer_pkg::TPC_W-1:0]    tpc_reg;
    logic [uer_pkg::SCNT_W-1:0]   scnt_reg;
    logic [uer_pkg::SETTLE_W-1:0] settle_ticks_reg;

    // Measurement state.
    logic [2:0]                           phase_reg, phase_next;
    logic [uer_pkg::PCNT_W-1:0]           pcnt_reg, pcnt_next;
    logic [uer_pkg::SAMPLE_W-1:0]         sidx_reg, sidx_next;
    logic [uer_pkg::ECHO_WIDTH_BITS-1:0]  width_reg, width_next;
    logic [uer_pkg::SUM_W-1:0]            sum_reg, sum_next;

    // Divider state.
    logic                        div_busy_reg;
    logic [uer_pkg::DCNT_W-1:0]  div_cnt_reg;
    logic [uer_pkg::NUM_W-1:0]   div_quo_reg;
    logic [uer_pkg::DEN_W-1:0]   div_rem_reg;
    logic [uer_pkg::DEN_W-1:0]   div_den_reg;

    // Output register.
    logic                        out_valid_reg;
    logic                        trig_out_reg;
    logic                        busy_out_reg;
    logic                        rv_out_reg;
    logic [uer_pkg::DIST_W-1:0]  dist_out_reg;

    logic                        in_fire;
    logic                        out_fire;
    logic                        set_done;
    logic [uer_pkg::EFF_W-1:0]   eff_n;
    logic [uer_pkg::PCNT_W:0]    pcnt_inc;
    logic [uer_pkg::SUM_W:0]     sum_add;

    logic [uer_pkg::DEN_W:0]     div_shift;
    logic                        div_qbit;
    logic [uer_pkg::DEN_W-1:0]   div_rem_new;
    logic [uer_pkg::NUM_W-1:0]   div_quo_new;
    logic [uer_pkg::DIST_W-1:0]  div_result;

    assign in_stall = div_busy_reg || (out_valid_reg && out_stall);
    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid_reg && !out_stall;

    assign out_valid           = out_valid_reg;
    assign trigger_level       = trig_out_reg;
    assign busy_res            = busy_out_reg;
    assign result_valid        = rv_out_reg;
    assign distance_sixteenths = dist_out_reg;

    assign eff_n    = uer_pkg::eff_samples(scnt_reg);
    assign pcnt_inc = {1'b0, pcnt_reg} + (uer_pkg::PCNT_W + 1)'(1);
    assign sum_add  = {1'b0, sum_reg} + (uer_pkg::SUM_W + 1)'(width_reg);

    // One tick of the measurement sequencer. Configuration is read live, so a
    // change between ticks takes effect at once.
    always_comb
    begin
        phase_next = phase_reg;
        pcnt_next  = pcnt_reg;
        sidx_next  = sidx_reg;
        width_next = width_reg;
        sum_next   = sum_reg;
        set_done   = 1'b0;
        case (phase_reg)
            PH_TRIG:
            begin
                pcnt_next = pcnt_inc[uer_pkg::PCNT_W-1:0];
                if (pcnt_inc >= (uer_pkg::PCNT_W + 1)'(trig_ticks_reg))
                begin
                    phase_next = PH_WAIT;
                end
            end
            PH_WAIT:
            begin
                width_next = '0;
                if (echo_level)
                begin
                    width_next = uer_pkg::ECHO_WIDTH_BITS'(1);
                    phase_next = PH_MEAS;
                end
            end
            PH_MEAS:
            begin
                if (echo_level)
                begin
                    if (width_reg != WIDTH_MAX)
                    begin
                        width_next = width_reg + uer_pkg::ECHO_WIDTH_BITS'(1);
                    end
                end
                else
                begin
                    sum_next   = sum_add[uer_pkg::SUM_W] ? SUM_MAX
                                                         : sum_add[uer_pkg::SUM_W-1:0];
                    sidx_next  = sidx_reg + uer_pkg::SAMPLE_W'(1);
                    phase_next = PH_SETTLE;
                    pcnt_next  = '0;
                end
            end
            PH_SETTLE:
            begin
                if (pcnt_reg >= uer_pkg::PCNT_W'(settle_ticks_reg))
                begin
                    if (uer_pkg::EFF_W'(sidx_reg) >= eff_n)
                    begin
                        set_done   = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_TRIG;
                    end
                    pcnt_next = '0;
                end
                else
                begin
                    pcnt_next = pcnt_inc[uer_pkg::PCNT_W-1:0];
                end
            end
            default:
            begin
                // Idle, and any unused code behaves as idle.
                phase_next = PH_IDLE;
                if (start_req)
                begin
                    phase_next = PH_TRIG;
                    pcnt_next  = '0;
                    sidx_next  = '0;
                    sum_next   = '0;
                    width_next = '0;
                end
            end
        endcase
    end

    // One restoring-division step: shift in the next numerator bit and
    // subtract the divisor when it fits. A zero divisor yields all ones,
    // which saturates to the full-scale distance.
    always_comb
    begin
        div_shift   = {div_rem_reg, div_quo_reg[uer_pkg::NUM_W-1]};
        div_qbit    = (div_shift >= {1'b0, div_den_reg});
        div_rem_new = div_qbit ? uer_pkg::DEN_W'(div_shift - {1'b0, div_den_reg})
                               : div_shift[uer_pkg::DEN_W-1:0];
        div_quo_new = {div_quo_reg[uer_pkg::NUM_W-2:0], div_qbit};
        if (div_quo_new[uer_pkg::NUM_W-1:uer_pkg::DIST_W] != '0)
        begin
            div_result = DIST_MAX;
        end
        else
        begin
            div_result = div_quo_new[uer_pkg::DIST_W-1:0];
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_ticks_reg   <= uer_pkg::TRIGGER_TICKS_RST;
            tpc_reg          <= uer_pkg::TICKS_PER_CM_RST;
            scnt_reg         <= uer_pkg::SAMPLE_COUNT_RST;
            settle_ticks_reg <= uer_pkg::SETTLE_TICKS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                uer_pkg::REG_TRIGGER_TICKS: trig_ticks_reg   <= cfg_data[uer_pkg::TRIG_W-1:0];
                uer_pkg::REG_TICKS_PER_CM:  tpc_reg          <= cfg_data[uer_pkg::TPC_W-1:0];
                uer_pkg::REG_SAMPLE_COUNT:  scnt_reg         <= cfg_data[uer_pkg::SCNT_W-1:0];
                uer_pkg::REG_SETTLE_TICKS:  settle_ticks_reg <= cfg_data[uer_pkg::SETTLE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Measurement state advances once per accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            pcnt_reg  <= '0;
            sidx_reg  <= '0;
            width_reg <= '0;
            sum_reg   <= '0;
        end
        else if (in_fire)
        begin
            phase_reg <= phase_next;
            pcnt_reg  <= pcnt_next;
            sidx_reg  <= sidx_next;
            width_reg <= width_next;
            sum_reg   <= sum_next;
        end
    end

    // Divider control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end
        else if (in_fire && set_done)
        begin
            div_busy_reg <= 1'b1;
            div_cnt_reg  <= uer_pkg::DCNT_W'(uer_pkg::NUM_W);
        end
        else if (div_busy_reg)
        begin
            div_cnt_reg <= div_cnt_reg - uer_pkg::DCNT_W'(1);
            if (div_cnt_reg == uer_pkg::DCNT_W'(1))
            begin
                div_busy_reg <= 1'b0;
            end
        end
    end

    // Divider datapath. The sum does not change on the finishing tick, so the
    // numerator is the stored sum times sixteen.
    always_ff @(posedge clk)
    begin
        if (in_fire && set_done)
        begin
            div_quo_reg <= {sum_reg, 4'b0000};
            div_rem_reg <= '0;
            div_den_reg <= uer_pkg::DEN_W'(tpc_reg) * uer_pkg::DEN_W'(eff_n);
        end
        else if (div_busy_reg)
        begin
            div_quo_reg <= div_quo_new;
            div_rem_reg <= div_rem_new;
        end
    end

    // Output register: an ordinary tick loads it directly; the finishing tick
    // loads it when the last quotient bit is out.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((in_fire && !set_done) ||
                 (div_busy_reg && div_cnt_reg == uer_pkg::DCNT_W'(1)))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && !set_done)
        begin
            trig_out_reg <= (phase_next == PH_TRIG);
            busy_out_reg <= (phase_next != PH_IDLE);
            rv_out_reg   <= 1'b0;
            dist_out_reg <= '0;
        end
        else if (div_busy_reg && div_cnt_reg == uer_pkg::DCNT_W'(1))
        begin
            trig_out_reg <= 1'b0;
            busy_out_reg <= 1'b0;
            rv_out_reg   <= 1'b1;
            dist_out_reg <= div_result;
        end
    end

    // No new tick is taken while the divider is still working.
    `UER_ASSERT_NOW(a_div_blocks_input, clk, rst_n, div_busy_reg, in_stall,
        "input accepted during division")

    // The last division step always delivers a finished average.
    `UER_ASSERT_NEXT(a_div_delivers, clk, rst_n,
        div_busy_reg && div_cnt_reg == uer_pkg::DCNT_W'(1),
        out_valid_reg && rv_out_reg && !busy_out_reg,
        "division end did not load a result")

    // A result is only shown with the sequencer back in idle.
    `UER_ASSERT_NOW(a_result_idle, clk, rst_n, out_valid_reg && rv_out_reg,
        !trig_out_reg && !busy_out_reg && phase_reg == PH_IDLE,
        "result shown while measurement still active")

    // Distance stays zero on ticks without a result.
    `UER_ASSERT_NOW(a_dist_zero, clk, rst_n, out_valid_reg && !rv_out_reg,
        dist_out_reg == '0,
        "nonzero distance without a result")

endmodule

`default_nettype wire
